// ===== src/tsz_pkg.sv =====
`default_nettype none
package tsz_pkg;

    localparam int MAX_TILES = 8;
    localparam int CNT_W     = 4;
    localparam int TI_W      = 3;
    localparam int BD_IDX_W  = 4;
    localparam int MAX_LOG2  = 4;
    localparam int RCP_SHIFT = 16;

    localparam logic [2:0] REG_PIC_W   = 3'd0;
    localparam logic [2:0] REG_PIC_H   = 3'd1;
    localparam logic [2:0] REG_TCOLS   = 3'd2;
    localparam logic [2:0] REG_TROWS   = 3'd3;
    localparam logic [2:0] REG_UNIFORM = 3'd4;
    localparam logic [2:0] REG_CWIDTHS = 3'd5;
    localparam logic [2:0] REG_RHEIGHT = 3'd6;
    localparam logic [2:0] REG_LOG2    = 3'd7;

    typedef struct packed {
        logic                      err;
        logic [MAX_TILES:0][7:0]   bd;
    } bounds_t;

    typedef struct packed {
        logic            in_pic;
        logic [TI_W-1:0] t;
        logic            start;
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      pos;
    } loc_t;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
            r = CNT_W'(1);
        else if (v > CNT_W'(MAX_TILES))
            r = CNT_W'(MAX_TILES);
        return r;
    endfunction

    // ceil(2^16 / n), exact quotient for dividends below 8192
    function automatic logic [16:0] recip(input logic [CNT_W-1:0] n);
        logic [16:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/tsz_bounds.sv =====
`default_nettype none
module tsz_bounds (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           total,
    input  wire logic [tsz_pkg::CNT_W-1:0] cnt,
    input  wire logic                 uniform,
    input  wire logic [63:0]          sizes,
    output tsz_pkg::bounds_t          bnd
);
    import tsz_pkg::*;

    logic [CNT_W-1:0]            n1_reg;
    logic [7:0]                  tot1_reg;
    logic                        uni1_reg;
    logic [MAX_TILES:0][10:0]    prod1_reg;
    logic [MAX_TILES:0][10:0]    ps1_reg;
    logic [MAX_TILES:0][10:0]    prod1_next;
    logic [MAX_TILES:0][10:0]    ps1_next;
    bounds_t                     bnd_reg;
    bounds_t                     bnd_next;
    logic [7:0]                  tot_c;
    logic [16:0]                 rcp;
    logic [27:0]                 q;

    assign tot_c = (total == 8'd0) ? 8'd1 : total;

    always_comb
    begin
        ps1_next[0]   = '0;
        prod1_next[0] = '0;
        for (int i = 1; i <= MAX_TILES; i++)
        begin
            prod1_next[i] = 11'(i) * {3'b0, tot_c};
            ps1_next[i]   = ps1_next[i-1] + {3'b0, sizes[8*(i-1) +: 8]};
        end
    end

    // stage 2: boundary per tile, entries past the count hold the total
    always_comb
    begin
        rcp = recip(n1_reg);
        q   = '0;
        bnd_next.err = !uni1_reg
                     && (ps1_reg[BD_IDX_W'(n1_reg - CNT_W'(1))] >= {3'b0, tot1_reg});
        for (int i = 0; i <= MAX_TILES; i++)
        begin
            q = {17'b0, prod1_reg[i]} * {11'b0, rcp};
            if (BD_IDX_W'(i) >= BD_IDX_W'(n1_reg))
                bnd_next.bd[i] = tot1_reg;
            else if (uni1_reg)
                bnd_next.bd[i] = q[RCP_SHIFT +: 8];
            else
                bnd_next.bd[i] = ps1_reg[i][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_reg   <= CNT_W'(1);
            tot1_reg <= 8'd1;
            uni1_reg <= 1'b1;
            bnd_reg  <= '0;
        end
        else
        begin
            n1_reg   <= clamp_cnt(cnt);
            tot1_reg <= tot_c;
            uni1_reg <= uniform;
            bnd_reg  <= bnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        ps1_reg   <= ps1_next;
    end

    assign bnd = bnd_reg;

endmodule
`default_nettype wire

// ===== src/tsz_locate.sv =====
`default_nettype none
module tsz_locate (
    input  wire logic                       clk,
    input  wire logic [11:0]                pos,
    input  wire logic [7:0]                 total,
    input  wire logic [tsz_pkg::CNT_W-1:0]  cnt,
    input  tsz_pkg::bounds_t                bnd,
    output tsz_pkg::loc_t                   loc
);
    import tsz_pkg::*;

    loc_t             loc_reg;
    loc_t             loc_next;
    logic [CNT_W-1:0] n;
    logic [7:0]       tot_c;

    assign n     = clamp_cnt(cnt);
    assign tot_c = (total == 8'd0) ? 8'd1 : total;

    always_comb
    begin
        loc_next.t     = '0;
        loc_next.start = 1'b0;
        for (int i = 0; i < MAX_TILES; i++)
        begin
            if (CNT_W'(i) < n && pos >= {4'b0, bnd.bd[i]})
                loc_next.t = TI_W'(i);
            if (CNT_W'(i) < n && pos == {4'b0, bnd.bd[i]})
                loc_next.start = 1'b1;
        end
        loc_next.in_pic = pos < {4'b0, tot_c};
        loc_next.b0     = bnd.bd[{1'b0, loc_next.t}];
        loc_next.b1     = bnd.bd[{1'b0, loc_next.t} + BD_IDX_W'(1)];
        loc_next.pos    = pos[7:0];
    end

    always_ff @(posedge clk)
    begin
        loc_reg <= loc_next;
    end

    assign loc = loc_reg;

endmodule
`default_nettype wire

// ===== src/tile_scan_and_zscan_address.sv =====
`default_nettype none
// Tile-scan and z-scan address unit.
// Configuration: write cfg_data to register cfg_index while cfg_we is high
// (0 picture width, 1 height, 2 tile columns, 3 tile rows, 4 uniform spacing,
// 5 column widths, 6 row heights, 7 log2 CTB over min TB). Write only while
// no item is in flight.
// Items: pulse start with tb_x/tb_y. busy is high in a register write cycle
// and the cycle after it while the boundary table catches up; otherwise an
// item can be given every cycle. Each item returns one result, shown for
// one cycle with done high: valid_res, config_error,
// ctb_ts_addr, tile_index, tile_start, zscan_addr.
// Pipeline: coordinate shift, tile lookup against the boundary table,
// three 8x8 multiplies, final sum and z-order merge. Tile boundaries come
// from the config registers through a two-stage table (uniform split via
// a reciprocal multiply) that runs alongside the item path.
// Throughput is one item per cycle while busy is low.
// Reset restores the default register values and drops any item in flight.
// The receiver cannot stall; results are not held.
module tile_scan_and_zscan_address (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         start,
    output wire logic         busy,
    input  wire logic [11:0]  tb_x,
    input  wire logic [11:0]  tb_y,
    output wire logic         done,
    output wire logic         valid_res,
    output wire logic         config_error,
    output wire logic [15:0]  ctb_ts_addr,
    output wire logic [5:0]   tile_index,
    output wire logic         tile_start,
    output wire logic [23:0]  zscan_addr
);
    import tsz_pkg::*;

    logic [7:0]       pic_w_reg, pic_h_reg;
    logic [CNT_W-1:0] tcols_reg, trows_reg;
    logic             uni_reg;
    logic [63:0]      cw_reg, rh_reg;
    logic [2:0]       log2_reg;
    logic             cfg_pend_reg;

    bounds_t          cbnd, rbnd;
    loc_t             lx, ly;
    logic [2:0]       d;
    logic [7:0]       pw;
    logic [CNT_W-1:0] nc;

    logic             v1_reg, v2_reg, v3_reg, done_reg;
    logic [11:0]      cx1_reg, cy1_reg;
    logic [3:0]       x1_reg, y1_reg, x2_reg, y2_reg;
    logic             err2_reg;
    logic             ok3_reg, err3_reg, start3_reg;
    logic [15:0]      m1_reg, m2_reg, m3_reg;
    logic [7:0]       off3_reg, il3_reg;
    logic [5:0]       tidx3_reg;
    logic [15:0]      ts;
    logic [7:0]       il_next;
    logic             vres_reg, err_reg, tstart_reg;
    logic [15:0]      ts_reg;
    logic [5:0]       tidx_reg;
    logic [23:0]      z_reg;

    assign d    = (log2_reg > 3'(MAX_LOG2)) ? 3'(MAX_LOG2) : log2_reg;
    assign pw   = (pic_w_reg == 8'd0) ? 8'd1 : pic_w_reg;
    assign nc   = clamp_cnt(tcols_reg);
    // boundary table is registered after the config registers, so busy also covers the pending flag
    assign busy = cfg_we || cfg_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pic_w_reg <= 8'd1;
            pic_h_reg <= 8'd1;
            tcols_reg <= CNT_W'(1);
            trows_reg <= CNT_W'(1);
            uni_reg   <= 1'b1;
            cw_reg    <= '0;
            rh_reg    <= '0;
            log2_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIC_W:   pic_w_reg <= cfg_data[7:0];
                REG_PIC_H:   pic_h_reg <= cfg_data[7:0];
                REG_TCOLS:   tcols_reg <= cfg_data[CNT_W-1:0];
                REG_TROWS:   trows_reg <= cfg_data[CNT_W-1:0];
                REG_UNIFORM: uni_reg   <= cfg_data[0];
                REG_CWIDTHS: cw_reg    <= cfg_data;
                REG_RHEIGHT: rh_reg    <= cfg_data;
                REG_LOG2:    log2_reg  <= cfg_data[2:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_pend_reg <= 1'b0;
        else
            cfg_pend_reg <= cfg_we;
    end

    tsz_bounds u_cbounds (
        .clk(clk), .rst_n(rst_n), .total(pic_w_reg), .cnt(tcols_reg),
        .uniform(uni_reg), .sizes(cw_reg), .bnd(cbnd)
    );

    tsz_bounds u_rbounds (
        .clk(clk), .rst_n(rst_n), .total(pic_h_reg), .cnt(trows_reg),
        .uniform(uni_reg), .sizes(rh_reg), .bnd(rbnd)
    );

    tsz_locate u_xloc (
        .clk(clk), .pos(cx1_reg), .total(pic_w_reg), .cnt(tcols_reg),
        .bnd(cbnd), .loc(lx)
    );

    tsz_locate u_yloc (
        .clk(clk), .pos(cy1_reg), .total(pic_h_reg), .cnt(trows_reg),
        .bnd(rbnd), .loc(ly)
    );

    always_comb
    begin
        il_next = '0;
        for (int i = 0; i < MAX_LOG2; i++)
        begin
            if (3'(i) < d)
            begin
                il_next[2*i]   = x2_reg[i];
                il_next[2*i+1] = y2_reg[i];
            end
        end
    end

    assign ts = m1_reg + m2_reg + m3_reg + {8'b0, off3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: CTB coordinate
        cx1_reg <= tb_x >> d;
        cy1_reg <= tb_y >> d;
        x1_reg  <= tb_x[3:0];
        y1_reg  <= tb_y[3:0];
        // stage 2: tile lookup runs in the locate units
        x2_reg   <= x1_reg;
        y2_reg   <= y1_reg;
        err2_reg <= cbnd.err || rbnd.err;
        // stage 3: products
        ok3_reg    <= !err2_reg && lx.in_pic && ly.in_pic;
        err3_reg   <= err2_reg;
        start3_reg <= lx.start && ly.start;
        m1_reg     <= {8'b0, pw} * {8'b0, ly.b0};
        m2_reg     <= {8'b0, ly.b1 - ly.b0} * {8'b0, lx.b0};
        m3_reg     <= {8'b0, ly.pos - ly.b0} * {8'b0, lx.b1 - lx.b0};
        off3_reg   <= lx.pos - lx.b0;
        tidx3_reg  <= 6'(ly.t * nc + {1'b0, lx.t});
        il3_reg    <= il_next;
        // stage 4: sum and z-order merge
        vres_reg   <= ok3_reg;
        err_reg    <= err3_reg;
        ts_reg     <= ok3_reg ? ts : '0;
        tidx_reg   <= ok3_reg ? tidx3_reg : '0;
        tstart_reg <= ok3_reg && start3_reg;
        z_reg      <= ok3_reg ? (({8'b0, ts} << {d, 1'b0}) | {16'b0, il3_reg}) : '0;
    end

    assign done         = done_reg;
    assign valid_res    = vres_reg;
    assign config_error = err_reg;
    assign ctb_ts_addr  = ts_reg;
    assign tile_index   = tidx_reg;
    assign tile_start   = tstart_reg;
    assign zscan_addr   = z_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done) else $error("result missing");
    a_err_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && config_error) |-> !valid_res) else $error("valid with config error");
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (ctb_ts_addr == 16'd0 && zscan_addr == 24'd0
                                  && !tile_start && tile_index == 6'd0))
        else $error("fields not cleared");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4)) else $error("result without item");

endmodule
`default_nettype wire

// ===== sim/tile_scan_and_zscan_address_tb.sv =====
`timescale 1ns / 1ps

module tile_scan_and_zscan_address_tb;
    import tsz_pkg::*;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
    } coord_t;

    typedef struct {
        logic        valid_res;
        logic        config_error;
        logic [15:0] ctb_ts_addr;
        logic [5:0]  tile_index;
        logic        tile_start;
        logic [23:0] zscan_addr;
    } addr_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        start;
    logic [11:0] tb_x;
    logic [11:0] tb_y;
    wire         busy;
    wire         done;
    wire         valid_res;
    wire         config_error;
    wire  [15:0] ctb_ts_addr;
    wire  [5:0]  tile_index;
    wire         tile_start;
    wire  [23:0] zscan_addr;

    tile_scan_and_zscan_address uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy), .tb_x(tb_x), .tb_y(tb_y),
        .done(done), .valid_res(valid_res), .config_error(config_error),
        .ctb_ts_addr(ctb_ts_addr), .tile_index(tile_index),
        .tile_start(tile_start), .zscan_addr(zscan_addr)
    );

    // shadow copy of the register file
    logic [7:0]  sh_pw, sh_ph;
    logic [3:0]  sh_cols, sh_rows;
    logic        sh_uni;
    logic [63:0] sh_cw, sh_rh;
    logic [2:0]  sh_d;

    coord_t    coord_q[$];
    addr_res_t addr_q[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        n_items = 0;
    int        n_invalid = 0;
    int        n_cfgerr = 0;
    int        n_phases = 0;
    bit        no_idle = 0;

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic int clamp_cnt_tb(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void axis_bounds(input int total, input int n, input bit uni,
                                        input logic [63:0] widths, output int bd[0:8],
                                        output bit err);
        int i;
        bd = '{default: 0};
        err = 0;
        if (uni) begin
            for (i = 1; i <= n; i++)
                bd[i] = (i * total) / n;
        end else begin
            for (i = 0; i + 1 < n; i++)
                bd[i + 1] = bd[i] + int'(widths[8*i +: 8]);
            if (bd[n - 1] >= total)
                err = 1;
            else
                bd[n] = total;
        end
    endfunction

    function automatic addr_res_t predict_addr(logic [11:0] x, logic [11:0] y);
        int pw, ph, nc, nr, d, cx, cy, tx, ty, ts, i;
        int cb[0:8];
        int rb[0:8];
        bit ec, er, sc, sr;
        logic [31:0] z;
        addr_res_t r;
        pw = clamp_cnt_tb(sh_pw, 255);
        ph = clamp_cnt_tb(sh_ph, 255);
        nc = clamp_cnt_tb(sh_cols, 8);
        nr = clamp_cnt_tb(sh_rows, 8);
        d  = (sh_d > 4) ? 4 : sh_d;
        cx = x >> d;
        cy = y >> d;
        axis_bounds(pw, nc, sh_uni, sh_cw, cb, ec);
        axis_bounds(ph, nr, sh_uni, sh_rh, rb, er);
        r = '{default: '0};
        r.config_error = ec | er;
        if (ec || er || cx >= pw || cy >= ph)
            return r;
        tx = 0; ty = 0; sc = 0; sr = 0;
        for (i = 0; i < nc; i++) begin
            if (cx >= cb[i]) tx = i;
            if (cx == cb[i]) sc = 1;
        end
        for (i = 0; i < nr; i++) begin
            if (cy >= rb[i]) ty = i;
            if (cy == rb[i]) sr = 1;
        end
        ts = pw * rb[ty] + (rb[ty+1] - rb[ty]) * cb[tx]
           + (cy - rb[ty]) * (cb[tx+1] - cb[tx]) + (cx - cb[tx]);
        z = 32'(ts) << (2 * d);
        for (i = 0; i < d; i++) begin
            z[2*i]   = x[i];
            z[2*i+1] = y[i];
        end
        r.valid_res   = 1;
        r.ctb_ts_addr = ts[15:0];
        r.tile_index  = 6'(ty * nc + tx);
        r.tile_start  = sc & sr;
        r.zscan_addr  = z[23:0];
        return r;
    endfunction

    // driver: one item per cycle unless idling or held by busy
    always @(posedge clk) begin
        coord_t c;
        if (rst_n) begin
            if (start && !busy) begin
                addr_q.push_back(predict_addr(tb_x, tb_y));
                n_items++;
            end
            if (start && busy) begin
                // item not taken yet, keep it on the ports
            end else if (coord_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 13)) begin
                c = coord_q.pop_front();
                start <= 1'b1;
                tb_x  <= c.x;
                tb_y  <= c.y;
            end else begin
                start <= 1'b0;
                tb_x  <= 12'($urandom);
                tb_y  <= 12'($urandom);
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        addr_res_t e;
        if (rst_n && done) begin
            if (addr_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = addr_q.pop_front();
                if (!e.valid_res) n_invalid++;
                if (e.config_error) n_cfgerr++;
                if (e.valid_res !== valid_res || e.config_error !== config_error ||
                    e.ctb_ts_addr !== ctb_ts_addr || e.tile_index !== tile_index ||
                    e.tile_start !== tile_start || e.zscan_addr !== zscan_addr) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp v=%0b err=%0b ts=%0d ti=%0d st=%0b z=%0d",
                                  " | got v=%0b err=%0b ts=%0d ti=%0d st=%0b z=%0d"},
                                 e.valid_res, e.config_error, e.ctb_ts_addr, e.tile_index,
                                 e.tile_start, e.zscan_addr, valid_res, config_error,
                                 ctb_ts_addr, tile_index, tile_start, zscan_addr);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            REG_PIC_W:   sh_pw   = v[7:0];
            REG_PIC_H:   sh_ph   = v[7:0];
            REG_TCOLS:   sh_cols = v[3:0];
            REG_TROWS:   sh_rows = v[3:0];
            REG_UNIFORM: sh_uni  = v[0];
            REG_CWIDTHS: sh_cw   = v;
            REG_RHEIGHT: sh_rh   = v;
            REG_LOG2:    sh_d    = v[2:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(int pw, int ph, int nc, int nr, bit uni,
                           logic [63:0] cw, logic [63:0] rh, int d);
        write_reg(REG_PIC_W, 64'(pw));
        write_reg(REG_PIC_H, 64'(ph));
        write_reg(REG_TCOLS, 64'(nc));
        write_reg(REG_TROWS, 64'(nr));
        write_reg(REG_UNIFORM, 64'(uni));
        write_reg(REG_CWIDTHS, cw);
        write_reg(REG_RHEIGHT, rh);
        write_reg(REG_LOG2, 64'(d));
        // let the boundary table settle
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_widths(int total, int n);
        logic [63:0] w;
        int i, lim;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 8) begin
            lim = 2 * total / clamp_cnt_tb(n, 8);
            for (i = 0; i < 8; i++)
                w[8*i +: 8] = 8'($urandom_range(0, lim > 255 ? 255 : lim));
        end
        return w;
    endfunction

    task automatic push_xy(int x, int y);
        coord_t c;
        c.x = 12'(x);
        c.y = 12'(y);
        coord_q.push_back(c);
    endtask

    // random coordinates, mostly inside the picture
    task automatic push_random(int cnt);
        int i, pw, ph, d;
        pw = clamp_cnt_tb(sh_pw, 255);
        ph = clamp_cnt_tb(sh_ph, 255);
        d  = (sh_d > 4) ? 4 : sh_d;
        for (i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 9) < 8)
                push_xy($urandom_range(0, (pw << d) - 1), $urandom_range(0, (ph << d) - 1));
            else
                push_xy($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
    endtask

    task automatic drain;
        while (coord_q.size() != 0 || start)
            @(posedge clk);
        while (addr_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        n_phases++;
    endtask

    initial begin
        int p;
        rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
        start = 0; tb_x = '0; tb_y = '0;
        sh_pw = 1; sh_ph = 1; sh_cols = 1; sh_rows = 1; sh_uni = 1;
        sh_cw = '0; sh_rh = '0; sh_d = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults: single CTB picture
        push_xy(0, 0); push_xy(1, 0); push_xy(0, 1); push_xy(4095, 4095);
        drain();

        // largest picture, most tiles, largest d
        set_all(255, 255, 8, 8, 1, '0, '0, 4);
        push_xy(0, 0); push_xy(4079, 4079); push_xy(4080, 0); push_xy(0, 4095);
        push_xy(4095, 4095); push_xy(1234, 2345); push_random(10);
        drain();

        // zero sizes and tile counts clamp up, oversized ones clamp down, d saturates
        set_all(0, 0, 0, 15, 1, '0, '0, 7);
        push_xy(0, 0); push_xy(15, 15); push_xy(16, 0); push_random(3);
        drain();

        // more tiles than CTBs: empty tiles
        set_all(3, 5, 8, 8, 1, '0, '0, 1);
        push_random(8);
        drain();

        // explicit sizes with a zero byte
        set_all(20, 12, 4, 3, 0, 64'h00_00_00_00_00_05_00_03, 64'h00_00_00_00_00_00_04_04, 2);
        push_random(8);
        drain();

        // explicit sizes leaving no room for the last tile
        set_all(10, 10, 3, 2, 0, 64'h00_00_00_00_00_00_05_05, 64'h02, 0);
        push_xy(0, 0); push_xy(9, 9); push_xy(100, 3);
        drain();

        for (p = 0; p < 12; p++) begin
            int pw, ph, nc, nr;
            pw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 24);
            ph = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 24);
            nc = $urandom_range(0, 15);
            nr = $urandom_range(0, 15);
            set_all(pw, ph, nc, nr, $urandom_range(0, 1),
                    rand_widths(pw, nc), rand_widths(ph, nr), $urandom_range(0, 7));
            no_idle = (p == 3);
            push_random(50);
            drain();
        end

        repeat (10) @(posedge clk);
        $display("%0d items over %0d register settings;", n_items, n_phases);
        $display("%0d outside or rejected, %0d with config error", n_invalid, n_cfgerr);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
